FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PWM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define PWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pwm_pkg.sv
package pwm_pkg;

   localparam int POWER_W = 21;
   localparam int VOLT_W  = 16;
   localparam int TIME_W  = 32;
   localparam int DEV_W   = 3;
   localparam int WIN_W   = 12;
   localparam int PCT_W   = 8;
   localparam int WINMS_W = 22;
   localparam int SPARE_W = 22;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 128;

   localparam logic CSR_WINDOW_SECONDS = 1'b0;
   localparam logic CSR_STRESS_PERCENT = 1'b1;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 12'd60;
   localparam logic [PCT_W-1:0] PERCENT_RESET = 8'd90;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_LOAD    = 9'b000000010,
      S_DROP_RD = 9'b000000100,
      S_DROP    = 9'b000001000,
      S_WRITE   = 9'b000010000,
      S_EV_RD   = 9'b000100000,
      S_EV_CHK  = 9'b001000000,
      S_DIV     = 9'b010000000,
      S_FIN     = 9'b100000000
   } state_type;

   typedef struct packed {
      logic slot_known;
      logic [POWER_W-1:0] latest_power;
      logic [POWER_W-1:0] latest_limit;
      logic [VOLT_W-1:0] latest_millivolts;
      logic [POWER_W-1:0] peak_power;
      logic throttle_state;
      logic [SPARE_W-1:0] spare_power;
      logic [POWER_W-1:0] window_mean;
      logic stressed;
   } result_type;

endpackage

FILE: rtl/pwm_ring.sv
module pwm_ring #(
   parameter int SLOTS = 8,
   parameter int DEPTH = 64,
   parameter int SLOT_W = 3,
   parameter int PTR_W = 6
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [PTR_W-1:0] wr_ptr,
   input  logic [pwm_pkg::TIME_W-1:0] wr_time,
   input  logic [pwm_pkg::POWER_W-1:0] wr_power,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic [PTR_W-1:0] rd_ptr,
   output logic [pwm_pkg::TIME_W-1:0] rd_time,
   output logic [pwm_pkg::POWER_W-1:0] rd_power
);

   localparam int ENTRY_W = pwm_pkg::TIME_W + pwm_pkg::POWER_W;

   logic [ENTRY_W-1:0] mem [SLOTS][DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot][wr_ptr] <= {wr_time, wr_power};
      end
      rd_data_ff <= mem[rd_slot][rd_ptr];
   end

   assign rd_time  = rd_data_ff[ENTRY_W-1:pwm_pkg::POWER_W];
   assign rd_power = rd_data_ff[pwm_pkg::POWER_W-1:0];

endmodule

FILE: rtl/pwm_div.sv
module pwm_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 7
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [STEP_W-1:0] step_ff;
   logic busy_ff;
   logic done_ff;
   logic [DEN_W:0] rem_shift;
   logic fits;

   // One quotient bit per cycle, restoring form.
   assign rem_shift = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign fits = rem_shift >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(NUM_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_shift - {1'b0, den_ff} : rem_shift;
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/power_window_monitor_core.sv
// A request passes S_LOAD, then S_DROP_RD and S_DROP if a full ring drops its oldest sample,
// S_WRITE, S_EV_RD and S_EV_CHK once per sample evicted and once more, S_DIV and S_FIN. The
// serial divider for the window mean runs over SUM_W bits, 28 at the default ring depth. A
// clear or an out-of-range device goes from S_LOAD to S_FIN. One request is in work at a
// time, the next taken in the cycle after the result registers; a stalled result holds it.
// Reset is synchronous and active high: slots read as empty, config returns to 60 s and 90 %.
module power_window_monitor_core #(
   parameter int DEVICE_SLOTS = 8,
   parameter int RING_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // device, sample_power, limit_power, supply_millivolts, throttle_flag, time_ms
   input  logic [pwm_pkg::REQ_DATA_W-1:0] req_tdata,
   // clear_slot
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // slot_known, latest_power, latest_limit, latest_millivolts, peak_power,
   // throttle_state, spare_power, window_mean, stressed
   output logic [pwm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [pwm_pkg::WIN_W-1:0] csr_data
);

   localparam int SLOT_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = pwm_pkg::POWER_W + CNT_W;
   localparam int PW = pwm_pkg::POWER_W;

   pwm_pkg::state_type state_ff, state_in;

   logic [pwm_pkg::WIN_W-1:0] win_sec_ff;
   logic [pwm_pkg::PCT_W-1:0] pct_ff;
   logic [pwm_pkg::WINMS_W-1:0] win_ms_ff;

   logic slot_valid_ff [DEVICE_SLOTS];
   logic [PW-1:0] peak_store_ff [DEVICE_SLOTS];
   logic [PTR_W-1:0] head_store_ff [DEVICE_SLOTS];
   logic [CNT_W-1:0] cnt_store_ff [DEVICE_SLOTS];
   logic [SUM_W-1:0] sum_store_ff [DEVICE_SLOTS];
   logic [PW-1:0] recent_power_ff [DEVICE_SLOTS];
   logic [PW-1:0] last_limit_ff [DEVICE_SLOTS];
   logic [pwm_pkg::VOLT_W-1:0] last_volt_ff [DEVICE_SLOTS];
   logic throttle_store_ff [DEVICE_SLOTS];

   logic clear_ff;
   logic [pwm_pkg::DEV_W-1:0] dev_ff;
   logic [PW-1:0] power_ff;
   logic [PW-1:0] limit_ff;
   logic [pwm_pkg::VOLT_W-1:0] volt_ff;
   logic throttle_ff;
   logic [pwm_pkg::TIME_W-1:0] now_ff;

   logic [PTR_W-1:0] head_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [PW-1:0] peak_ff;
   logic stressed_ff;

   pwm_pkg::result_type rsp_ff;
   logic rsp_valid_ff;

   logic [SLOT_W-1:0] slot;
   logic in_range;
   logic req_fire;
   logic [PTR_W-1:0] head_next;
   logic [CNT_W:0] pos_sum;
   logic [PTR_W-1:0] wr_pos;
   logic [pwm_pkg::TIME_W-1:0] rd_time;
   logic [PW-1:0] rd_power;
   logic too_old;
   logic div_start;
   logic div_done;
   logic [SUM_W-1:0] quotient;
   logic [PW-1:0] peak_new;
   logic [27:0] power_x100_ff;
   logic [28:0] limit_x_pct_ff;

   assign slot = SLOT_W'(dev_ff);
   assign in_range = 32'(dev_ff) < DEVICE_SLOTS;
   assign req_tready = state_ff == pwm_pkg::S_IDLE;
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign head_next = (32'(head_ff) == RING_DEPTH - 1) ? '0 : head_ff + 1'b1;
   assign pos_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(cnt_ff);
   assign wr_pos = (32'(pos_sum) >= RING_DEPTH) ?
      PTR_W'(pos_sum - (CNT_W+1)'(RING_DEPTH)) : PTR_W'(pos_sum);
   assign too_old = ({1'b0, rd_time} + 33'(win_ms_ff)) < {1'b0, now_ff};
   assign peak_new = (power_ff > peak_store_ff[slot]) ? power_ff : peak_store_ff[slot];
   assign div_start = (state_ff == pwm_pkg::S_EV_CHK) && !(cnt_ff != '0 && too_old);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pwm_pkg::S_IDLE:    if (req_fire) state_in = pwm_pkg::S_LOAD;
         pwm_pkg::S_LOAD: begin
            if (clear_ff || !in_range) begin
               state_in = pwm_pkg::S_FIN;
            end else if (32'(cnt_store_ff[slot]) >= RING_DEPTH) begin
               state_in = pwm_pkg::S_DROP_RD;
            end else begin
               state_in = pwm_pkg::S_WRITE;
            end
         end
         pwm_pkg::S_DROP_RD: state_in = pwm_pkg::S_DROP;
         pwm_pkg::S_DROP:    state_in = pwm_pkg::S_WRITE;
         pwm_pkg::S_WRITE:   state_in = pwm_pkg::S_EV_RD;
         pwm_pkg::S_EV_RD:   state_in = pwm_pkg::S_EV_CHK;
         pwm_pkg::S_EV_CHK:  state_in = div_start ? pwm_pkg::S_DIV : pwm_pkg::S_EV_RD;
         pwm_pkg::S_DIV:     if (div_done) state_in = pwm_pkg::S_FIN;
         pwm_pkg::S_FIN:     if (!rsp_valid_ff || rsp_tready) state_in = pwm_pkg::S_IDLE;
         default:            state_in = pwm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwm_pkg::S_IDLE;
         win_sec_ff <= pwm_pkg::WINDOW_RESET;
         pct_ff <= pwm_pkg::PERCENT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_index == pwm_pkg::CSR_WINDOW_SECONDS) begin
            win_sec_ff <= csr_data;
         end
         if (csr_valid && csr_index == pwm_pkg::CSR_STRESS_PERCENT) begin
            pct_ff <= csr_data[pwm_pkg::PCT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ms_ff <= pwm_pkg::WINMS_W'(win_sec_ff) * pwm_pkg::WINMS_W'(1000);
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         clear_ff <= req_tuser;
         dev_ff <= req_tdata[2:0];
         power_ff <= req_tdata[23:3];
         limit_ff <= req_tdata[44:24];
         volt_ff <= req_tdata[60:45];
         throttle_ff <= req_tdata[61];
         now_ff <= req_tdata[93:62];
      end
   end

   // Working copy of the slot's ring state, peak and stress check while the request is in work.
   always_ff @(posedge clock) begin
      case (state_ff)
         pwm_pkg::S_LOAD: begin
            head_ff <= head_store_ff[slot];
            cnt_ff <= cnt_store_ff[slot];
            sum_ff <= sum_store_ff[slot];
            peak_ff <= peak_new;
            power_x100_ff <= 28'(power_ff) * 28'd100;
            limit_x_pct_ff <= 29'(limit_ff) * 29'(pct_ff);
         end
         pwm_pkg::S_DROP: begin
            sum_ff <= sum_ff - SUM_W'(rd_power);
            head_ff <= head_next;
            cnt_ff <= cnt_ff - 1'b1;
         end
         pwm_pkg::S_WRITE: begin
            sum_ff <= sum_ff + SUM_W'(power_ff);
            cnt_ff <= cnt_ff + 1'b1;
            stressed_ff <= (limit_ff != '0 && 29'(power_x100_ff) >= limit_x_pct_ff) ||
               throttle_ff;
         end
         pwm_pkg::S_EV_CHK: begin
            if (!div_start) begin
               sum_ff <= sum_ff - SUM_W'(rd_power);
               head_ff <= head_next;
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEVICE_SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
            peak_store_ff[i] <= '0;
            head_store_ff[i] <= '0;
            cnt_store_ff[i] <= '0;
            sum_store_ff[i] <= '0;
         end
      end else if (state_ff == pwm_pkg::S_LOAD && in_range) begin
         if (clear_ff) begin
            slot_valid_ff[slot] <= 1'b0;
            peak_store_ff[slot] <= '0;
            head_store_ff[slot] <= '0;
            cnt_store_ff[slot] <= '0;
            sum_store_ff[slot] <= '0;
         end else begin
            slot_valid_ff[slot] <= 1'b1;
            peak_store_ff[slot] <= peak_new;
         end
      end else if (div_start) begin
         head_store_ff[slot] <= head_ff;
         cnt_store_ff[slot] <= cnt_ff;
         sum_store_ff[slot] <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pwm_pkg::S_LOAD && in_range && !clear_ff) begin
         recent_power_ff[slot] <= power_ff;
         last_limit_ff[slot] <= limit_ff;
         last_volt_ff[slot] <= volt_ff;
         throttle_store_ff[slot] <= throttle_ff;
      end
   end

   pwm_ring #(
      .SLOTS(DEVICE_SLOTS),
      .DEPTH(RING_DEPTH),
      .SLOT_W(SLOT_W),
      .PTR_W(PTR_W)
   ) u_ring (
      .clock(clock),
      .wr_en(state_ff == pwm_pkg::S_WRITE),
      .wr_slot(slot),
      .wr_ptr(wr_pos),
      .wr_time(now_ff),
      .wr_power(power_ff),
      .rd_slot(slot),
      .rd_ptr(head_ff),
      .rd_time(rd_time),
      .rd_power(rd_power)
   );

   pwm_div #(
      .NUM_W(SUM_W),
      .DEN_W(CNT_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(sum_ff),
      .divisor(cnt_ff),
      .done(div_done),
      .quotient(quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == pwm_pkg::S_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pwm_pkg::S_FIN && (!rsp_valid_ff || rsp_tready)) begin
         if (clear_ff || !in_range) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.slot_known <= 1'b1;
            rsp_ff.latest_power <= power_ff;
            rsp_ff.latest_limit <= limit_ff;
            rsp_ff.latest_millivolts <= volt_ff;
            rsp_ff.peak_power <= peak_ff;
            rsp_ff.throttle_state <= throttle_ff;
            rsp_ff.spare_power <= {1'b0, limit_ff} - {1'b0, power_ff};
            rsp_ff.window_mean <= quotient[PW-1:0];
            rsp_ff.stressed <= stressed_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_ff.stressed, rsp_ff.window_mean, rsp_ff.spare_power,
      rsp_ff.throttle_state, rsp_ff.peak_power, rsp_ff.latest_millivolts,
      rsp_ff.latest_limit, rsp_ff.latest_power, rsp_ff.slot_known};

endmodule

FILE: rtl/pwm_checker.sv
`include "assert_macros.svh"

module pwm_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [pwm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A held result stays offered until it is taken.
   `PWM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")

   // An unknown slot reports every other field as zero.
   `PWM_ASSERT(a_unknown_zero, clock, reset, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[127:1] == '0, "unknown slot not zero")

   // Throttling always marks the device stressed.
   `PWM_ASSERT(a_throttle_stress, clock, reset, rsp_tvalid && rsp_tdata[80] |-> rsp_tdata[124], "throttle without stress")

   // Only one request is in work: the port closes right after an accept.
   `PWM_ASSERT(a_one_in_work, clock, reset, req_tvalid && req_tready |=> !req_tready, "second request taken")

   // No result is offered in the cycle after reset.
   `PWM_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "result after reset")

endmodule

bind power_window_monitor_core pwm_checker u_pwm_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
